[hw/rtl/swm_pkg.sv]
// ----------------------------------------------------------------------------
// swm_pkg: shared types and constants for the sliding-window median filter
// Defaults, the configuration field width, and the flag and control structs
// that pass between the cells and the top level.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int MAX_WINDOW_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 32;
    localparam int CFG_BITS        = 7;
    localparam int RESET_WINDOW    = 3;

    // Rank flags a cell shows to its neighbors.
    typedef struct packed {
        logic g;   // entry ranks above the new sample, or cell is empty
        logic r;   // entry is the evicted one or sits above it
    } swm_flags_t;

    // Broadcast control from the top level to every cell.
    typedef struct packed {
        logic load;      // a transaction is being taken this cycle
        logic has_del;   // window is full, the oldest entry goes
        logic del_low;   // evicted entry ranks at or below the new sample
    } swm_ctrl_t;

endpackage

[hw/rtl/swm_cell.sv]
// ----------------------------------------------------------------------------
// swm_cell: one slot of the sorted window
// Holds a sample and its age; each transaction it keeps its entry, takes a
// neighbor's, or takes the new sample, so the row stays in ascending order.
// ----------------------------------------------------------------------------
module swm_cell
    import swm_pkg::*;
#(
    parameter int W  = SAMPLE_BITS_DEF,
    parameter int AW = 6
) (
    input  logic              aclk,
    input  swm_ctrl_t         ctrl,
    input  logic              valid,
    input  logic [W-1:0]      x,
    input  logic [W-1:0]      key_d,
    input  logic [AW-1:0]     age_last,
    input  logic              med_sel,
    input  logic [W-1:0]      left_val,
    input  logic [AW-1:0]     left_age,
    input  swm_flags_t        left_flags,
    input  logic [W-1:0]      right_val,
    input  logic [AW-1:0]     right_age,
    input  swm_flags_t        right_flags,
    output logic [W-1:0]      val,
    output logic [AW-1:0]     age,
    output swm_flags_t        flags,
    output logic              del,
    output logic [W-1:0]      del_val,
    output logic [W-1:0]      med_val
);

    logic [W-1:0]  val_reg, val_next;
    logic [AW-1:0] age_reg, age_next;
    logic [W-1:0]  key_v, key_x;
    logic          above_del;

    // sign flip makes unsigned order match signed order
    assign key_v = {~val_reg[W-1], val_reg[W-2:0]};
    assign key_x = {~x[W-1], x[W-2:0]};

    assign del       = ctrl.has_del && valid && (age_reg == age_last);
    assign above_del = ctrl.has_del && valid && !del && (key_v >= key_d);
    assign flags.g   = !valid || (key_v > key_x);
    assign flags.r   = del || above_del;

    assign val     = val_reg;
    assign age     = age_reg;
    assign del_val = del ? val_reg : '0;
    assign med_val = med_sel ? val_reg : '0;

    always_comb begin
        val_next = val_reg;
        age_next = age_reg + AW'(1);
        if (ctrl.del_low) begin
            // hole below the insert point: slide down, new sample on top
            if (flags.r && !right_flags.g) begin
                val_next = right_val;
                age_next = right_age + AW'(1);
            end else if (flags.r && !flags.g && right_flags.g) begin
                val_next = x;
                age_next = '0;
            end
        end else begin
            // hole above the insert point (or none): slide up
            if (flags.g && !left_flags.g) begin
                val_next = x;
                age_next = '0;
            end else if (flags.g && left_flags.g && !left_flags.r) begin
                val_next = left_val;
                age_next = left_age + AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            val_reg <= val_next;
            age_reg <= age_next;
        end
    end

endmodule

[hw/rtl/swm_gather.sv]
// ----------------------------------------------------------------------------
// swm_gather: OR tree over the cell row
// Combines the one-hot masked words of the evicted entry and of the median.
// ----------------------------------------------------------------------------
module swm_gather
    import swm_pkg::*;
#(
    parameter int W = SAMPLE_BITS_DEF,
    parameter int N = MAX_WINDOW_DEF
) (
    input  logic [N-1:0][W-1:0] del_vals,
    input  logic [N-1:0][W-1:0] med_vals,
    output logic [W-1:0]        del_word,
    output logic [W-1:0]        med_word
);

    always_comb begin
        del_word = '0;
        med_word = '0;
        for (int i = 0; i < N; i++) begin
            del_word = del_word | del_vals[i];
            med_word = med_word | med_vals[i];
        end
    end

endmodule

[hw/rtl/sliding_window_median.sv]
// ----------------------------------------------------------------------------
// sliding_window_median: running lower median over the last K samples
// Sorted row of cells with age tags, one sample per transaction.
// ----------------------------------------------------------------------------
// When a sample is taken, all MAX_WINDOW cells compare against the new
// sample at once; once the window is full the oldest entry (age K-1) drops
// out, and the new one slots into place in the same clock, so the block
// sustains one transaction per cycle unless intake is stalled by
// back-pressure. The median, element (K-1)/2 of the sorted row, reaches the
// master side once the row has settled at the edge that takes the sample and
// the median has moved into the output register; back-pressure on the master
// side stalls intake only once both the pending slot and the output register
// are occupied. Nothing comes out until K samples have entered. Writing
// cfg_wr_data (window size K; 0 acts as 1, values above MAX_WINDOW clamp)
// empties the window; write it only while the block is idle. Window
// contents are not reset, only the size, fill count and stream flags are.
// ----------------------------------------------------------------------------
module sliding_window_median
    import swm_pkg::*;
#(
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int DW = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [CFG_BITS-1:0] cfg_wr_data,   // window_size
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [DW-1:0]       s_tdata,       // sample
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [DW-1:0]       m_tdata        // median
);

    localparam int W  = SAMPLE_BITS;
    localparam int N  = MAX_WINDOW;
    localparam int AW = (N > 1) ? $clog2(N) : 1;   // age / index width
    localparam int KW = $clog2(N + 1);             // fill count width

    // configuration
    logic [CFG_BITS-1:0] win_reg;
    logic [KW-1:0]       k_eff;
    logic [AW-1:0]       age_last;   // age of the entry due out, K-1
    logic [AW-1:0]       med_idx;    // (K-1)/2

    always_comb begin
        if (win_reg == '0) begin
            k_eff = KW'(1);
        end else if (32'(win_reg) > 32'(N)) begin
            k_eff = KW'(N);
        end else begin
            k_eff = KW'(win_reg);
        end
    end

    assign age_last = AW'(k_eff - KW'(1));
    assign med_idx  = AW'((k_eff - KW'(1)) >> 1);

    // stream control
    logic            fill_full;
    logic [KW-1:0]   fill_reg, fill_next;
    logic            pend_reg, pend_next;   // row holds a median to read out
    logic            out_valid_reg;
    logic [W-1:0]    out_data_reg;
    logic            s_accept, pend_move, emits;

    assign fill_full = (fill_reg == k_eff);
    assign pend_move = pend_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !pend_reg || pend_move;
    assign s_accept  = s_tvalid && s_tready;
    assign fill_next = fill_full ? fill_reg : fill_reg + KW'(1);
    assign emits     = (fill_next == k_eff);

    always_comb begin
        pend_next = pend_reg;
        if (s_accept && emits) begin
            pend_next = 1'b1;
        end else if (pend_move) begin
            pend_next = 1'b0;
        end
    end

    // cell row
    logic [W-1:0]             x;
    logic [W-1:0]             del_word, med_word, key_d, key_x;
    swm_ctrl_t                ctrl;
    logic [N-1:0][W-1:0]      cell_val;
    logic [N-1:0][AW-1:0]     cell_age;
    swm_flags_t [N-1:0]       cell_flags;
    logic [N-1:0]             cell_del;
    logic [N-1:0][W-1:0]      cell_del_val;
    logic [N-1:0][W-1:0]      cell_med_val;

    assign x     = s_tdata[W-1:0];
    assign key_x = {~x[W-1], x[W-2:0]};
    assign key_d = {~del_word[W-1], del_word[W-2:0]};

    assign ctrl.load    = s_accept;
    assign ctrl.has_del = fill_full;
    assign ctrl.del_low = fill_full && (key_d <= key_x);

    for (genvar i = 0; i < N; i++) begin : g_cell
        logic [W-1:0]  lv, rv;
        logic [AW-1:0] la, ra;
        swm_flags_t    lf, rf;
        logic          valid, med_sel;

        assign valid   = (KW'(i) < fill_reg);
        assign med_sel = (med_idx == AW'(i));

        if (i == 0) begin : g_first
            assign lv = '0;
            assign la = '0;
            assign lf = '{g: 1'b0, r: 1'b0};
        end else begin : g_mid_l
            assign lv = cell_val[i-1];
            assign la = cell_age[i-1];
            assign lf = cell_flags[i-1];
        end

        if (i == N - 1) begin : g_last
            assign rv = '0;
            assign ra = '0;
            assign rf = '{g: 1'b1, r: 1'b0};
        end else begin : g_mid_r
            assign rv = cell_val[i+1];
            assign ra = cell_age[i+1];
            assign rf = cell_flags[i+1];
        end

        swm_cell #(.W(W), .AW(AW)) u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .valid       (valid),
            .x           (x),
            .key_d       (key_d),
            .age_last    (age_last),
            .med_sel     (med_sel),
            .left_val    (lv),
            .left_age    (la),
            .left_flags  (lf),
            .right_val   (rv),
            .right_age   (ra),
            .right_flags (rf),
            .val         (cell_val[i]),
            .age         (cell_age[i]),
            .flags       (cell_flags[i]),
            .del         (cell_del[i]),
            .del_val     (cell_del_val[i]),
            .med_val     (cell_med_val[i])
        );
    end

    swm_gather #(.W(W), .N(N)) u_gather (
        .del_vals (cell_del_val),
        .med_vals (cell_med_val),
        .del_word (del_word),
        .med_word (med_word)
    );

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg       <= CFG_BITS'(RESET_WINDOW);
            fill_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                win_reg  <= cfg_wr_data;
                fill_reg <= '0;
            end else if (s_accept) begin
                fill_reg <= fill_next;
            end
            pend_reg <= pend_next;
            if (pend_move) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // median is read from the settled row
    always_ff @(posedge aclk) begin
        if (pend_move) begin
            out_data_reg <= med_word;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = DW'(out_data_reg);

`ifndef ASSERT_OFF
    // fill count never runs past the window
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= k_eff)
        else $error("fill count exceeds window size");

    // a full window evicts exactly one entry
    a_one_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && fill_full) |-> $onehot(cell_del))
        else $error("eviction not one-hot");

    // a pending median reaches an empty output register next cycle
    a_pend_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("pending median not forwarded");

    // a window-size write empties the window
    a_cfg_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> (fill_reg == '0))
        else $error("window not cleared on config write");
`endif

endmodule
